FILE: rtl/mdr_pkg.sv
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared constants and types for the multiply/divide register unit: register
// map, access codes and sequencer states.
// ----------------------------------------------------------------------------
package mdr_pkg;

  localparam int unsigned AddrW = 15;
  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned CntW  = 4;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;

  // write map
  localparam addr_t ADDR_MPY_A   = 15'h4202;
  localparam addr_t ADDR_MPY_B   = 15'h4203;
  localparam addr_t ADDR_DIV_LO  = 15'h4204;
  localparam addr_t ADDR_DIV_HI  = 15'h4205;
  localparam addr_t ADDR_DIV_B   = 15'h4206;
  // read map
  localparam addr_t ADDR_QUOT_LO = 15'h4214;
  localparam addr_t ADDR_QUOT_HI = 15'h4215;
  localparam addr_t ADDR_PR_LO   = 15'h4216;
  localparam addr_t ADDR_PR_HI   = 15'h4217;

  localparam word_t QUOT_DIV0    = 16'hFFFF;

  // access direction
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // last step index of each operation
  localparam logic [CntW-1:0] MUL_LAST = 4'd7;
  localparam logic [CntW-1:0] DIV_LAST = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } state_e;

endpackage

FILE: rtl/multiply_divide_registers_top.sv
// ----------------------------------------------------------------------------
// multiply_divide_registers_top
// Byte-wide register-mapped 8x8 multiply and 16/8 divide unit built around
// one shared 16-bit add/subtract unit stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Timing: plain register writes, reads and bad accesses give their result
// word in the cycle after acceptance; a multiplier write runs 8 shift-add
// steps and a non-zero divisor write 16 restoring steps, all through the
// single shared adder. busy_o is high while a step runs.
// Throughput: one word per cycle for plain accesses while idle; no access is
// taken during a step run. The receiver cannot stall. Reset clears all state.
module multiply_divide_registers_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  mdr_pkg::addr_t     register_address_i,
  input  mdr_pkg::byte_t     write_data_i,
  output logic               done_o,
  output mdr_pkg::byte_t     read_data_o,
  output logic               bad_register_o
);
  import mdr_pkg::*;

  state_e            state_q, state_d;
  byte_t             mcand_q, mcand_d;
  byte_t             mplier_q, mplier_d;
  word_t             dividend_q, dividend_d;
  byte_t             divisor_q, divisor_d;
  word_t             quot_q, quot_d;
  word_t             prod_q, prod_d;
  word_t             acc_q, acc_d;
  word_t             work_q, work_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              done_q, done_d;
  byte_t             rd_q, rd_d;
  logic              bad_q, bad_d;

  // shared adder
  word_t             alu_a, alu_b;
  logic              alu_sub;
  logic [WordW:0]    alu_res;

  logic [ByteW:0]    rem_sh;
  logic              q_bit;
  byte_t             rem_new;

  assign alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                           : ({1'b0, alu_a} + {1'b0, alu_b});

  always_comb begin
    state_d    = state_q;
    mcand_d    = mcand_q;
    mplier_d   = mplier_q;
    dividend_d = dividend_q;
    divisor_d  = divisor_q;
    quot_d     = quot_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    work_d     = work_q;
    cnt_d      = cnt_q;
    done_d     = 1'b0;
    rd_d       = '0;
    bad_d      = 1'b0;
    alu_a      = '0;
    alu_b      = '0;
    alu_sub    = 1'b0;
    rem_sh     = {acc_q[ByteW-1:0], work_q[WordW-1]};
    q_bit      = 1'b0;
    rem_new    = rem_sh[ByteW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (action_i == ACT_WRITE) begin
            unique case (register_address_i)
              ADDR_MPY_A: begin
                mcand_d = write_data_i;
                done_d  = 1'b1;
              end
              ADDR_MPY_B: begin
                mplier_d = write_data_i;
                acc_d    = '0;
                cnt_d    = '0;
                state_d  = ST_MUL;
              end
              ADDR_DIV_LO: begin
                dividend_d = {dividend_q[WordW-1:ByteW], write_data_i};
                done_d     = 1'b1;
              end
              ADDR_DIV_HI: begin
                dividend_d = {write_data_i, dividend_q[ByteW-1:0]};
                done_d     = 1'b1;
              end
              ADDR_DIV_B: begin
                divisor_d = write_data_i;
                if (write_data_i == '0) begin
                  quot_d = QUOT_DIV0;
                  prod_d = dividend_q;
                  done_d = 1'b1;
                end else begin
                  work_d  = dividend_q;
                  acc_d   = '0;
                  cnt_d   = '0;
                  state_d = ST_DIV;
                end
              end
              default: begin
                bad_d  = 1'b1;
                done_d = 1'b1;
              end
            endcase
          end else begin
            done_d = 1'b1;
            unique case (register_address_i)
              ADDR_QUOT_LO: rd_d = quot_q[ByteW-1:0];
              ADDR_QUOT_HI: rd_d = quot_q[WordW-1:ByteW];
              ADDR_PR_LO:   rd_d = prod_q[ByteW-1:0];
              ADDR_PR_HI:   rd_d = prod_q[WordW-1:ByteW];
              default:      bad_d = 1'b1;
            endcase
          end
        end
      end

      ST_MUL: begin
        // msb-first shift-add
        alu_a = {acc_q[WordW-2:0], 1'b0};
        alu_b = mplier_q[~cnt_q[2:0]] ? {{(WordW-ByteW){1'b0}}, mcand_q} : '0;
        acc_d = alu_res[WordW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          prod_d  = alu_res[WordW-1:0];
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_DIV: begin
        // restoring step: borrow out means the trial subtract failed
        alu_a   = {{(WordW-ByteW-1){1'b0}}, rem_sh};
        alu_b   = {{(WordW-ByteW){1'b0}}, divisor_q};
        alu_sub = 1'b1;
        q_bit   = ~alu_res[WordW];
        rem_new = q_bit ? alu_res[ByteW-1:0] : rem_sh[ByteW-1:0];
        acc_d   = {{(WordW-ByteW){1'b0}}, rem_new};
        work_d  = {work_q[WordW-2:0], q_bit};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          quot_d  = {work_q[WordW-2:0], q_bit};
          prod_d  = {{(WordW-ByteW){1'b0}}, rem_new};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mcand_q    <= '0;
      mplier_q   <= '0;
      dividend_q <= '0;
      divisor_q  <= '0;
      quot_q     <= '0;
      prod_q     <= '0;
      acc_q      <= '0;
      work_q     <= '0;
      cnt_q      <= '0;
      done_q     <= 1'b0;
      rd_q       <= '0;
      bad_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      mcand_q    <= mcand_d;
      mplier_q   <= mplier_d;
      dividend_q <= dividend_d;
      divisor_q  <= divisor_d;
      quot_q     <= quot_d;
      prod_q     <= prod_d;
      acc_q      <= acc_d;
      work_q     <= work_d;
      cnt_q      <= cnt_d;
      done_q     <= done_d;
      rd_q       <= rd_d;
      bad_q      <= bad_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign read_data_o    = rd_q;
  assign bad_register_o = bad_q;

  // a bad access never returns data
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_register_o) |-> (read_data_o == '0))
    else $error("bad access returned non-zero data");

  // a read is answered in the next cycle
  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && action_i == ACT_READ) |=> (done_o && !busy_o))
    else $error("read not answered in one cycle");

  // every end of an arithmetic run delivers a word
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("operation ended without a result word");

  // no word appears mid-operation
  a_no_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !done_o)
    else $error("result word while busy");

  // a divide step run holds the unit until its last step
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q != DIV_LAST) |=> (state_q == ST_DIV))
    else $error("divide left early");

endmodule
